// ===== hdl/mlfq_pkg.sv =====
// Shared types and constants for the multilevel feedback queue scheduler.
`default_nettype none
package mlfq_pkg;

    localparam int NUM_LEVELS_DEF    = 4;
    localparam int QUEUE_DEPTH_DEF   = 256;
    localparam int MAX_PROCESSES_DEF = 256;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_REQUEUE = 3'd1;
    localparam logic [2:0] ACT_BLOCKED = 3'd2;
    localparam logic [2:0] ACT_TERM    = 3'd3;
    localparam logic [2:0] ACT_DROP    = 3'd4;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd1;
    localparam logic [1:0] ST_TERM    = 2'd2;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_Q0   = 3'd1;
    localparam logic [2:0] REG_Q1   = 3'd2;
    localparam logic [2:0] REG_Q2   = 3'd3;
    localparam logic [2:0] REG_Q3   = 3'd4;

    typedef struct packed {
        logic load;
        logic push;
        logic pop;
        logic finish;
    } mlfq_cmd_t;

    typedef struct packed {
        logic pop_req;
    } mlfq_status_t;

endpackage
`default_nettype wire

// ===== hdl/mlfq_fifo_process_scheduler.sv =====
// Top level of the multilevel feedback queue process scheduler.
//
//   channel   handshake              contents
//   in        in_valid / in_stall    kind, cpu_index, has_current, pid, priority_req,
//                                    proc_state, quantum_used, slice_granted
//   out       out_valid / out_stall  one result beat per input beat
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each beat has four steps: capture, enqueue, dequeue from the queue memory, result.
// The single-port queue memory is written when enqueuing and read when dequeuing.
// Reset clears pointers, counts, finished count and mode; the memory needs no clearing.
// A stalled result holds the next beat in the result state until it is taken.
`default_nettype none
module mlfq_fifo_process_scheduler
#(
    parameter int NUM_LEVELS  = mlfq_pkg::NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = mlfq_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [1:0]  cpu_index,
    input  wire logic        has_current,
    input  wire logic [7:0]  pid,
    input  wire logic [1:0]  priority_req,
    input  wire logic [1:0]  proc_state,
    input  wire logic [15:0] quantum_used,
    input  wire logic [15:0] slice_granted,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       echo_cpu,
    output logic             selected_valid,
    output logic [7:0]       selected_pid,
    output logic [1:0]       selected_level,
    output logic [15:0]      selected_quantum,
    output logic [2:0]       outgoing_action,
    output logic [1:0]       outgoing_priority,
    output logic [15:0]      outgoing_quantum,
    output logic [15:0]      finished_total,
    output logic             queue_overflow,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import mlfq_pkg::*;

    mlfq_cmd_t    cmd;
    mlfq_status_t status;

    assign cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mlfq_dp #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .kind              (kind),
        .cpu_index         (cpu_index),
        .has_current       (has_current),
        .pid               (pid),
        .priority_req      (priority_req),
        .proc_state        (proc_state),
        .quantum_used      (quantum_used),
        .slice_granted     (slice_granted),
        .echo_cpu          (echo_cpu),
        .selected_valid    (selected_valid),
        .selected_pid      (selected_pid),
        .selected_level    (selected_level),
        .selected_quantum  (selected_quantum),
        .outgoing_action   (outgoing_action),
        .outgoing_priority (outgoing_priority),
        .outgoing_quantum  (outgoing_quantum),
        .finished_total    (finished_total),
        .queue_overflow    (queue_overflow)
    );

endmodule
`default_nettype wire

// ===== hdl/mlfq_ctrl.sv =====
// Controller state machine sequencing capture, enqueue, dequeue and result.
`default_nettype none
module mlfq_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire mlfq_pkg::mlfq_status_t status,
    output mlfq_pkg::mlfq_cmd_t        cmd
);
    import mlfq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PUSH = 4'b0010,
        S_POP  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_POP;
            end
            S_POP:
            begin
                cmd.pop    = status.pop_req;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mlfq_dp.sv =====
// Datapath with queue store, pointers, counts, quantum table and result registers.
`default_nettype none
module mlfq_dp
#(
    parameter int NUM_LEVELS  = mlfq_pkg::NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = mlfq_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mlfq_pkg::mlfq_cmd_t    cmd,
    output mlfq_pkg::mlfq_status_t      status,
    input  wire logic                   cfg_we,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [15:0]            cfg_data,
    input  wire logic                   kind,
    input  wire logic [1:0]             cpu_index,
    input  wire logic                   has_current,
    input  wire logic [7:0]             pid,
    input  wire logic [1:0]             priority_req,
    input  wire logic [1:0]             proc_state,
    input  wire logic [15:0]            quantum_used,
    input  wire logic [15:0]            slice_granted,
    output logic [1:0]                  echo_cpu,
    output logic                        selected_valid,
    output logic [7:0]                  selected_pid,
    output logic [1:0]                  selected_level,
    output logic [15:0]                 selected_quantum,
    output logic [2:0]                  outgoing_action,
    output logic [1:0]                  outgoing_priority,
    output logic [15:0]                 outgoing_quantum,
    output logic [15:0]                 finished_total,
    output logic                        queue_overflow
);
    import mlfq_pkg::*;

    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = LW + PW;
    localparam logic [LW-1:0] LAST = LW'(NUM_LEVELS - 1);

    logic [7:0]  store_mem [0:(1 << AW) - 1];
    logic [PW-1:0] head_reg [NUM_LEVELS];
    logic [PW-1:0] tail_reg [NUM_LEVELS];
    logic [CW-1:0] cnt_reg  [NUM_LEVELS];
    logic [15:0] fin_reg;
    logic        mode_reg;
    logic [15:0] q_reg [4];

    logic        kind_reg, cur_reg;
    logic [1:0]  cpu_reg, st_reg;
    logic [7:0]  pid_reg;
    logic [LW-1:0] prio_reg;
    logic        ge_reg;
    logic        fifo_reg;

    logic        push_en, do_push;
    logic [LW-1:0] push_lv;
    logic [2:0]  act_c;
    logic [LW-1:0] opr_c;
    logic        pop_found;
    logic [LW-1:0] pop_lv;

    logic [2:0]  act_reg;
    logic [LW-1:0] opr_reg;
    logic        ovf_reg;
    logic        selv_reg;
    logic [LW-1:0] sell_reg;
    logic [7:0]  rd_reg;

    logic        o_selv;
    logic [7:0]  o_pid;
    logic [1:0]  o_lv;
    logic [15:0] o_selq;
    logic [2:0]  o_act;
    logic [1:0]  o_pr;
    logic [15:0] o_q;
    logic [15:0] o_fin;
    logic        o_ovf;
    logic [1:0]  o_cpu;

    function automatic logic [15:0] qsel(input logic [LW-1:0] lv, input logic [15:0] q0,
        input logic [15:0] q1, input logic [15:0] q2, input logic [15:0] q3);
        logic [2:0] v;
        v = 3'(lv);
        case (v)
            3'd0:    qsel = q0;
            3'd1:    qsel = q1;
            3'd2:    qsel = q2;
            default: qsel = q3;
        endcase
    endfunction

    function automatic logic [LW-1:0] clampl(input logic [2:0] lv);
        if (32'(lv) >= NUM_LEVELS)
        begin
            clampl = LAST;
        end
        else
        begin
            clampl = LW'(lv);
        end
    endfunction

    // Disposition of the admitted or outgoing process.
    always_comb
    begin
        push_en = 1'b0;
        push_lv = '0;
        act_c   = ACT_NONE;
        opr_c   = '0;
        if (kind_reg)
        begin
            push_en = 1'b1;
            push_lv = fifo_reg ? '0 : prio_reg;
            opr_c   = push_lv;
        end
        else if (cur_reg)
        begin
            if (fifo_reg)
            begin
                if (st_reg == ST_BLOCKED)
                begin
                    act_c = ACT_BLOCKED;
                end
                else if (st_reg == ST_TERM)
                begin
                    act_c = ACT_TERM;
                end
                else if (st_reg == ST_READY)
                begin
                    push_en = 1'b1;
                end
            end
            else if (ge_reg)
            begin
                push_en = 1'b1;
                push_lv = clampl(3'(prio_reg) + 3'd1);
                opr_c   = push_lv;
            end
            else
            begin
                act_c = ACT_BLOCKED;
                opr_c = (prio_reg != '0 && st_reg == ST_BLOCKED) ? prio_reg - LW'(1) : prio_reg;
            end
        end
        do_push = push_en && (32'(cnt_reg[push_lv]) < QUEUE_DEPTH);
    end

    always_comb
    begin
        pop_found = 1'b0;
        pop_lv    = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (cnt_reg[i] != '0 && (!fifo_reg || i == 0))
            begin
                pop_found = 1'b1;
                pop_lv    = LW'(i);
            end
        end
    end

    assign status.pop_req = pop_found && !kind_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push && do_push)
        begin
            store_mem[{push_lv, tail_reg[push_lv]}] <= pid_reg;
        end
        if (cmd.pop)
        begin
            rd_reg <= store_mem[{pop_lv, head_reg[pop_lv]}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            fin_reg  <= '0;
            mode_reg <= 1'b0;
            q_reg[0] <= 16'd1;
            q_reg[1] <= 16'd2;
            q_reg[2] <= 16'd4;
            q_reg[3] <= 16'd8;
            selv_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE: mode_reg <= cfg_data[0];
                    REG_Q0:   q_reg[0] <= cfg_data;
                    REG_Q1:   q_reg[1] <= cfg_data;
                    REG_Q2:   q_reg[2] <= cfg_data;
                    REG_Q3:   q_reg[3] <= cfg_data;
                    default:  ;
                endcase
            end
            if (cmd.load)
            begin
                selv_reg <= 1'b0;
            end
            if (cmd.push)
            begin
                if (do_push)
                begin
                    tail_reg[push_lv] <= (32'(tail_reg[push_lv]) + 1 >= QUEUE_DEPTH)
                        ? '0 : tail_reg[push_lv] + PW'(1);
                    cnt_reg[push_lv]  <= cnt_reg[push_lv] + CW'(1);
                end
                if (act_c == ACT_TERM && fin_reg != 16'hFFFF)
                begin
                    fin_reg <= fin_reg + 16'd1;
                end
            end
            if (cmd.pop)
            begin
                head_reg[pop_lv] <= (32'(head_reg[pop_lv]) + 1 >= QUEUE_DEPTH)
                    ? '0 : head_reg[pop_lv] + PW'(1);
                cnt_reg[pop_lv]  <= cnt_reg[pop_lv] - CW'(1);
                selv_reg <= 1'b1;
                sell_reg <= pop_lv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            cur_reg  <= has_current;
            cpu_reg  <= cpu_index;
            st_reg   <= proc_state;
            pid_reg  <= pid;
            prio_reg <= clampl({1'b0, priority_req});
            ge_reg   <= (quantum_used >= slice_granted);
            fifo_reg <= mode_reg;
        end
        if (cmd.push)
        begin
            act_reg <= push_en ? (do_push ? ACT_REQUEUE : ACT_DROP) : act_c;
            ovf_reg <= push_en && !do_push;
            opr_reg <= opr_c;
        end
        if (cmd.finish)
        begin
            o_cpu  <= cpu_reg;
            o_selv <= selv_reg;
            o_pid  <= selv_reg ? rd_reg : 8'd0;
            o_lv   <= selv_reg ? 2'(sell_reg) : 2'd0;
            o_selq <= selv_reg ? qsel(sell_reg, q_reg[0], q_reg[1], q_reg[2], q_reg[3]) : 16'd0;
            o_act  <= act_reg;
            o_pr   <= 2'(opr_reg);
            o_q    <= (kind_reg || cur_reg)
                      ? qsel(opr_reg, q_reg[0], q_reg[1], q_reg[2], q_reg[3]) : 16'd0;
            o_fin  <= fin_reg;
            o_ovf  <= ovf_reg;
        end
    end

    assign echo_cpu          = o_cpu;
    assign selected_valid    = o_selv;
    assign selected_pid      = o_pid;
    assign selected_level    = o_lv;
    assign selected_quantum  = o_selq;
    assign outgoing_action   = o_act;
    assign outgoing_priority = o_pr;
    assign outgoing_quantum  = o_q;
    assign finished_total    = o_fin;
    assign queue_overflow    = o_ovf;

endmodule
`default_nettype wire

// ===== test/mlfq_fifo_process_scheduler_tb.sv =====
// Self-checking testbench for the multilevel feedback queue process scheduler.
`timescale 1ns / 1ps
module mlfq_fifo_process_scheduler_tb;
    import mlfq_pkg::*;

    localparam int LEVELS = 4;
    localparam int DEPTH = 256;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        kind;
        logic [1:0]  cpu;
        logic        has_cur;
        logic [7:0]  pid;
        logic [1:0]  prio;
        logic [1:0]  state;
        logic [15:0] used;
        logic [15:0] total;
    } sched_req_t;

    typedef struct packed {
        logic [1:0]  cpu;
        logic        sel_valid;
        logic [7:0]  sel_pid;
        logic [1:0]  sel_level;
        logic [15:0] sel_quantum;
        logic [2:0]  action;
        logic [1:0]  out_prio;
        logic [15:0] out_quantum;
        logic [15:0] finished;
        logic        overflow;
    } sched_decision_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic kind = 1'b0;
    logic [1:0] cpu_index = '0;
    logic has_current = 1'b0;
    logic [7:0] pid = '0;
    logic [1:0] priority_req = '0;
    logic [1:0] proc_state = '0;
    logic [15:0] quantum_used = '0;
    logic [15:0] slice_granted = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] echo_cpu;
    logic selected_valid;
    logic [7:0] selected_pid;
    logic [1:0] selected_level;
    logic [15:0] selected_quantum;
    logic [2:0] outgoing_action;
    logic [1:0] outgoing_priority;
    logic [15:0] outgoing_quantum;
    logic [15:0] finished_total;
    logic queue_overflow;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    mlfq_fifo_process_scheduler dut (.*);

    logic        fifo_mode;
    logic [15:0] slice_tab [LEVELS];
    logic [7:0]  ready_q [LEVELS][$];
    logic [15:0] finished_cnt;

    sched_req_t      pending_reqs [$];
    sched_decision_t expected_decisions [$];
    int error_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic logic [1:0] clamp_lvl(int lv);
        return (lv >= LEVELS) ? 2'(LEVELS - 1) : 2'(lv);
    endfunction

    function automatic logic enqueue_pid(logic [1:0] lv, logic [7:0] p);
        if (ready_q[lv].size() >= DEPTH)
            return 1'b0;
        ready_q[lv].push_back(p);
        return 1'b1;
    endfunction

    function automatic sched_decision_t schedule_decision(sched_req_t r);
        sched_decision_t d;
        logic [1:0] lv;
        d = '0;
        d.cpu = r.cpu;
        if (r.kind) begin
            lv = fifo_mode ? 2'd0 : r.prio;
            if (enqueue_pid(lv, r.pid))
                d.action = ACT_REQUEUE;
            else
            begin
                d.action = ACT_DROP;
                d.overflow = 1'b1;
            end
            d.out_prio = lv;
            d.out_quantum = slice_tab[lv];
        end
        else
        begin
            if (r.has_cur) begin
                if (fifo_mode) begin
                    d.out_quantum = slice_tab[0];
                    if (r.state == ST_BLOCKED)
                        d.action = ACT_BLOCKED;
                    else if (r.state == ST_TERM) begin
                        d.action = ACT_TERM;
                        if (finished_cnt != 16'hFFFF)
                            finished_cnt++;
                    end
                    else if (r.state == ST_READY) begin
                        if (enqueue_pid(2'd0, r.pid))
                            d.action = ACT_REQUEUE;
                        else
                        begin
                            d.action = ACT_DROP;
                            d.overflow = 1'b1;
                        end
                    end
                end
                else if (r.used >= r.total) begin
                    lv = clamp_lvl(int'(r.prio) + 1);
                    d.out_prio = lv;
                    d.out_quantum = slice_tab[lv];
                    if (enqueue_pid(lv, r.pid))
                        d.action = ACT_REQUEUE;
                    else
                    begin
                        d.action = ACT_DROP;
                        d.overflow = 1'b1;
                    end
                end
                else
                begin
                    lv = (r.prio > 0 && r.state == ST_BLOCKED) ? r.prio - 2'd1 : r.prio;
                    d.out_prio = lv;
                    d.out_quantum = slice_tab[lv];
                    d.action = ACT_BLOCKED;
                end
            end
            for (int i = 0; i < (fifo_mode ? 1 : LEVELS); i++) begin
                if (ready_q[i].size() != 0) begin
                    d.sel_valid = 1'b1;
                    d.sel_pid = ready_q[i].pop_front();
                    d.sel_level = 2'(i);
                    d.sel_quantum = slice_tab[i];
                    break;
                end
            end
        end
        d.finished = finished_cnt;
        return d;
    endfunction

    always @(posedge clk) begin
        if (in_valid && !in_stall)
            expected_decisions.push_back(schedule_decision(pending_reqs.pop_front()));
        if ((in_valid && in_stall) ||
            (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)) begin
            sched_req_t r;
            r = pending_reqs[0];
            if (!(in_valid && in_stall)) begin
                kind <= r.kind;
                cpu_index <= r.cpu;
                has_current <= r.has_cur;
                pid <= r.pid;
                priority_req <= r.prio;
                proc_state <= r.state;
                quantum_used <= r.used;
                slice_granted <= r.total;
            end
            in_valid <= 1'b1;
        end
        else
            in_valid <= 1'b0;
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (out_valid && !out_stall) begin
            if (expected_decisions.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                sched_decision_t e;
                e = expected_decisions.pop_front();
                if (echo_cpu !== e.cpu) report_mismatch("echo_cpu", echo_cpu, e.cpu);
                if (selected_valid !== e.sel_valid)
                    report_mismatch("selected_valid", selected_valid, e.sel_valid);
                if (selected_pid !== e.sel_pid)
                    report_mismatch("selected_pid", selected_pid, e.sel_pid);
                if (selected_level !== e.sel_level)
                    report_mismatch("selected_level", selected_level, e.sel_level);
                if (selected_quantum !== e.sel_quantum)
                    report_mismatch("selected_quantum", selected_quantum, e.sel_quantum);
                if (outgoing_action !== e.action)
                    report_mismatch("outgoing_action", outgoing_action, e.action);
                if (outgoing_priority !== e.out_prio)
                    report_mismatch("outgoing_priority", outgoing_priority, e.out_prio);
                if (outgoing_quantum !== e.out_quantum)
                    report_mismatch("outgoing_quantum", outgoing_quantum, e.out_quantum);
                if (finished_total !== e.finished)
                    report_mismatch("finished_total", finished_total, e.finished);
                if (queue_overflow !== e.overflow)
                    report_mismatch("queue_overflow", queue_overflow, e.overflow);
            end
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_MODE)
            fifo_mode = val[0];
        else
            slice_tab[idx - REG_Q0] = val;
        @(posedge clk);
    endtask

    task automatic drain_all();
        while (pending_reqs.size() != 0 || in_valid || expected_decisions.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic sched_req_t random_req(int admit_pct);
        sched_req_t r;
        r.kind = ($urandom_range(99) < admit_pct);
        r.cpu = 2'($urandom);
        r.has_cur = ($urandom_range(3) != 0);
        r.pid = 8'($urandom);
        r.prio = 2'($urandom);
        r.state = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        case ($urandom_range(3))
            0: begin r.used = 16'($urandom); r.total = 16'($urandom); end
            1: begin r.total = 16'($urandom_range(1, 40)); r.used = r.total; end
            2: begin r.total = 16'($urandom_range(1, 40)); r.used = r.total - 16'd1; end
            default: begin r.used = 16'($urandom_range(0, 9)); r.total = 16'($urandom); end
        endcase
        return r;
    endfunction

    function automatic sched_req_t make_req(logic k, logic hc, logic [7:0] p, logic [1:0] pr,
                                            logic [1:0] st, logic [15:0] u, logic [15:0] t);
        sched_req_t r;
        r = '{k, 2'($urandom), hc, p, pr, st, u, t};
        return r;
    endfunction

    initial begin
        fifo_mode = 1'b0;
        slice_tab = '{16'd1, 16'd2, 16'd4, 16'd8};
        finished_cnt = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_reqs.push_back(make_req(1'b0, 1'b0, 8'd0, 2'd0, ST_READY, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(1'b1, 1'b0, 8'hFF, 2'd3, ST_READY, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(make_req(1'b1, 1'b1, 8'h00, 2'd0, ST_TERM, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(1'b1, 1'b0, 8'h5A, 2'd1, ST_BLOCKED, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(1'b1, 1'b0, 8'hA5, 2'd2, ST_READY, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(1'b0, 1'b1, 8'h11, 2'd3, ST_READY, 16'hFFFF, 16'd0));
        pending_reqs.push_back(make_req(1'b0, 1'b1, 8'h22, 2'd2, ST_BLOCKED, 16'd0, 16'hFFFF));
        pending_reqs.push_back(make_req(1'b0, 1'b1, 8'h33, 2'd0, ST_BLOCKED, 16'd1, 16'd5));
        pending_reqs.push_back(make_req(1'b0, 1'b1, 8'h44, 2'd1, ST_TERM, 16'd7, 16'd7));
        pending_reqs.push_back(make_req(1'b0, 1'b1, 8'h55, 2'd2, ST_READY, 16'd3, 16'd9));
        pending_reqs.push_back(make_req(1'b0, 1'b1, 8'h66, 2'd1, 2'd3, 16'd9, 16'd3));
        for (int i = 0; i < 6; i++)
            pending_reqs.push_back(make_req(1'b0, 1'b0, 8'd0, 2'd0, ST_READY, 16'd0, 16'd0));
        drain_all();

        write_reg(REG_MODE, 16'd1);
        write_reg(REG_Q0, 16'hFFFF);
        pending_reqs.push_back(make_req(1'b1, 1'b0, 8'h77, 2'd3, ST_READY, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(1'b0, 1'b1, 8'h88, 2'd2, ST_READY, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(1'b0, 1'b1, 8'h99, 2'd1, ST_BLOCKED, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(1'b0, 1'b1, 8'hAA, 2'd0, ST_TERM, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(1'b0, 1'b1, 8'hBB, 2'd0, 2'd3, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(1'b0, 1'b0, 8'h00, 2'd0, ST_READY, 16'd0, 16'd0));
        drain_all();

        // Fill level zero past its depth so the overflow path is exercised.
        send_idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < DEPTH + 3; i++)
            pending_reqs.push_back(make_req(1'b1, 1'b0, 8'($urandom), 2'($urandom),
                                            ST_READY, 16'd0, 16'd0));
        pending_reqs.push_back(make_req(1'b0, 1'b1, 8'hCC, 2'd0, ST_READY, 16'd0, 16'd0));
        for (int i = 0; i < 40; i++)
            pending_reqs.push_back(random_req(0));
        drain_all();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 57; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 57; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase
            write_reg(REG_MODE, (phase == 3) ? 16'd1 : 16'd0);
            write_reg(REG_Q0, (phase == 1) ? 16'd1 : 16'($urandom_range(1, 65535)));
            write_reg(REG_Q1, (phase == 2) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
            write_reg(REG_Q2, (phase == 4) ? 16'd1 : 16'($urandom_range(1, 65535)));
            write_reg(REG_Q3, (phase == 5) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
            for (int i = 0; i < 70; i++)
                pending_reqs.push_back(random_req(45));
            if (phase == 2) begin
                while (pending_reqs.size() > 35)
                    @(posedge clk);
                while (expected_decisions.size() != 0 || in_valid || pending_reqs.size() != 0)
                begin
                    if (pending_reqs.size() == 0 && expected_decisions.size() == 0)
                        break;
                    @(posedge clk);
                end
            end
            for (int i = 0; i < 10; i++)
                pending_reqs.push_back(random_req(45));
            drain_all();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/mlfq_pkg.sv
hdl/mlfq_ctrl.sv
hdl/mlfq_dp.sv
hdl/mlfq_fifo_process_scheduler.sv
test/mlfq_fifo_process_scheduler_tb.sv
